[rtl/ikr_pkg.sv]
package ikr_pkg;

   localparam int RADICAND_W = 64;
   localparam int DEGREE_W   = 7;
   localparam int ROOT_W     = 64;

   typedef struct packed {
      logic [RADICAND_W-1:0] radicand;
      logic [DEGREE_W-1:0]   degree;
   } req_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic              bad_degree;
   } rsp_type;

endpackage

[rtl/integer_kth_root.sv]
// channel | direction | word                      | handshake
// req     | in        | radicand, degree          | req_valid / req_ready
// rsp     | out       | root, bad_degree          | rsp_valid / rsp_ready
//
// one word at a time; req_ready is high only while no word is being worked on
// degree 0, degree 1 and radicand 0 or 1: straight from accept to ST_FINISH
// otherwise ST_BOUND steps that size the root, then one probe per root bit,
// each probe up to degree multiplies (ST_MUL_LO, ST_MUL_HI when the high half is
// nonzero, ST_CHECK) on the one shared half-width multiplier
// reset is synchronous and clears the sequencer and rsp_valid
// a result held by rsp_ready low does not stop the next word from being accepted
module integer_kth_root #(
   parameter int DATA_WIDTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ikr_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output ikr_pkg::rsp_type rsp_data
);

   import ikr_pkg::*;

   localparam int HW = (DATA_WIDTH + 1) / 2;
   localparam int LW = DATA_WIDTH - HW;
   localparam int SW = 3 * HW + 1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_BOUND  = 6'b000010,
      ST_MUL_LO = 6'b000100,
      ST_MUL_HI = 6'b001000,
      ST_CHECK  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [DATA_WIDTH-1:0] x_ff, x_in;
   logic [DEGREE_W-1:0]   deg_ff, deg_in;
   logic [DEGREE_W-1:0]   rem_ff, rem_in;
   logic [DEGREE_W-1:0]   cnt_ff, cnt_in;
   logic [HW-1:0]         mask_ff, mask_in;
   logic [HW-1:0]         root_ff, root_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [2*HW-1:0]       plo_ff, plo_in;
   logic                  hi_used_ff, hi_used_in;
   logic [DATA_WIDTH-1:0] res_ff, res_in;
   logic                  bad_ff, bad_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [DATA_WIDTH-1:0] x_new;
   logic [HW-1:0]         cand;
   logic [HW-1:0]         mul_a;
   logic [2*HW-1:0]       mul_p;
   logic [LW-1:0]         acc_hi;
   logic [SW-1:0]         sum;
   logic                  exceed;
   logic                  load_rsp;

   assign x_new  = req_data.radicand[DATA_WIDTH-1:0];
   assign cand   = root_ff | mask_ff;
   assign acc_hi = acc_ff[DATA_WIDTH-1:HW];
   assign mul_a  = (state_ff == ST_MUL_HI) ? HW'(acc_hi) : acc_ff[HW-1:0];

   ikr_mul #(
      .WIDTH(HW)
   ) u_mul (
      .clock(clock),
      .a    (mul_a),
      .b    (cand),
      .prod (mul_p)
   );

   assign sum    = hi_used_ff ? ((SW'(mul_p) << HW) + SW'(plo_ff)) : SW'(mul_p);
   assign exceed = sum > SW'(x_ff);

   assign load_rsp  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      deg_in       = deg_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      mask_in      = mask_ff;
      root_in      = root_ff;
      acc_in       = acc_ff;
      plo_in       = plo_ff;
      hi_used_in   = hi_used_ff;
      res_in       = res_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in    = x_new;
               deg_in  = req_data.degree;
               rem_in  = DEGREE_W'(DATA_WIDTH);
               mask_in = HW'(1);
               root_in = '0;
               priority if (req_data.degree == '0) begin
                  res_in   = '0;
                  bad_in   = 1'b1;
                  state_in = ST_FINISH;
               end else if (req_data.degree == DEGREE_W'(1) || x_new < DATA_WIDTH'(2)) begin
                  res_in   = x_new;
                  bad_in   = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  bad_in   = 1'b0;
                  state_in = ST_BOUND;
               end
            end
         end
         ST_BOUND: begin
            if (rem_ff <= deg_ff) begin
               acc_in   = DATA_WIDTH'(1);
               cnt_in   = deg_ff;
               state_in = ST_MUL_LO;
            end else begin
               rem_in  = rem_ff - deg_ff;
               mask_in = mask_ff << 1;
            end
         end
         ST_MUL_LO: begin
            hi_used_in = (acc_hi != '0);
            state_in   = (acc_hi != '0) ? ST_MUL_HI : ST_CHECK;
         end
         ST_MUL_HI: begin
            plo_in   = mul_p;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!exceed && cnt_ff != DEGREE_W'(1)) begin
               acc_in   = sum[DATA_WIDTH-1:0];
               cnt_in   = cnt_ff - DEGREE_W'(1);
               state_in = ST_MUL_LO;
            end else begin
               if (!exceed) begin
                  root_in = cand;
               end
               mask_in = mask_ff >> 1;
               if (mask_ff == HW'(1)) begin
                  res_in   = DATA_WIDTH'(exceed ? root_ff : cand);
                  state_in = ST_FINISH;
               end else begin
                  acc_in   = DATA_WIDTH'(1);
                  cnt_in   = deg_ff;
                  state_in = ST_MUL_LO;
               end
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.root       = ROOT_W'(res_ff);
               rsp_data_in.bad_degree = bad_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      deg_ff      <= deg_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      mask_ff     <= mask_in;
      root_ff     <= root_in;
      acc_ff      <= acc_in;
      plo_ff      <= plo_in;
      hi_used_ff  <= hi_used_in;
      res_ff      <= res_in;
      bad_ff      <= bad_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/ikr_mul.sv]
module ikr_mul #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic [WIDTH-1:0]   a,
   input  logic [WIDTH-1:0]   b,
   output logic [2*WIDTH-1:0] prod
);

   logic [2*WIDTH-1:0] prod_ff;
   logic [2*WIDTH-1:0] prod_in;

   assign prod_in = a * b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[rtl/ikr_check.sv]
module ikr_check (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input ikr_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ikr_pkg::rsp_type rsp_data
);

   import ikr_pkg::*;

   // a held result word stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word dropped or changed while stalled");

   // an offered request word stays until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req word dropped or changed while stalled");

   // a flagged degree always comes with a zero root
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_degree |-> rsp_data.root == '0)
      else $error("bad_degree with nonzero root");

   // one word in flight: no accept right after an accept
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while busy");

   // no result appears without an earlier accepted word
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("rsp word without pending req");

endmodule

bind integer_kth_root ikr_check u_check (.*);
